@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the inactivity blank timer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the property holds at every clock edge outside of reset.
`define IBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define IBT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/ibt_pkg.sv @@
// Package with the types and constants of the inactivity blank timer.
package ibt_pkg;

  localparam int CNT_W  = 17;
  localparam int LOOP_W = 16;
  localparam int SEC_W  = 14;

  localparam logic [SEC_W-1:0] SECONDS_MIN   = SEC_W'(1);
  localparam logic [SEC_W-1:0] SECONDS_MAX   = SEC_W'(9999);
  localparam logic [SEC_W-1:0] SECONDS_CEIL  = SEC_W'(10000);
  localparam logic [SEC_W-1:0] SECONDS_RESET = SEC_W'(60);
  localparam logic [CNT_W-1:0] TICKS_PER_SEC = CNT_W'(10);
  localparam logic [CNT_W-1:0] RELOAD_RESET  = CNT_W'(600);

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_EVENT = 1'b1
  } kind_t;

  typedef struct packed {
    logic blanked;
    logic pattern_change;
    logic force_black;
    logic unblank_request;
    logic blank_request;
  } result_t;

endpackage

@@ rtl/ibt_step.sv @@
// Next-state and result logic of the inactivity blank timer for one item.
`include "assert_macros.svh"

module ibt_step #(
  parameter int PATTERN_TICKS = 600,
  parameter int STALL_LIMIT   = 40,
  localparam int PCW = $clog2(PATTERN_TICKS),
  localparam int SCW = $clog2(STALL_LIMIT + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  input  ibt_pkg::kind_t              kind,
  input  logic                        buttons_held,
  input  logic [ibt_pkg::LOOP_W-1:0]  loop_count,
  input  logic [ibt_pkg::CNT_W-1:0]   reload,
  input  logic [ibt_pkg::CNT_W-1:0]   countdown,
  input  logic                        blanked,
  input  logic [SCW-1:0]              stall_cnt,
  input  logic [ibt_pkg::LOOP_W-1:0]  last_loop,
  input  logic [PCW-1:0]              pattern_cnt,
  output logic [ibt_pkg::CNT_W-1:0]   countdown_nxt,
  output logic                        blanked_nxt,
  output logic [SCW-1:0]              stall_cnt_nxt,
  output logic [ibt_pkg::LOOP_W-1:0]  last_loop_nxt,
  output logic [PCW-1:0]              pattern_cnt_nxt,
  output ibt_pkg::result_t            result
);

  localparam logic [PCW:0]   PATTERN_END = (PCW + 1)'(PATTERN_TICKS);
  localparam logic [SCW-1:0] STALL_END   = SCW'(STALL_LIMIT);

  logic [PCW:0] pattern_inc;
  logic [SCW-1:0] stall_inc;

  assign pattern_inc = {1'b0, pattern_cnt} + (PCW + 1)'(1);
  assign stall_inc   = stall_cnt + SCW'(1);

  always_comb begin
    countdown_nxt   = countdown;
    blanked_nxt     = blanked;
    stall_cnt_nxt   = stall_cnt;
    last_loop_nxt   = last_loop;
    pattern_cnt_nxt = pattern_cnt;
    result          = '0;
    unique case (kind)
      ibt_pkg::KIND_TICK: begin
        if (blanked) begin
          if (pattern_inc >= PATTERN_END) begin
            result.pattern_change = 1'b1;
            pattern_cnt_nxt       = '0;
          end else begin
            pattern_cnt_nxt = pattern_inc[PCW-1:0];
          end
          if (loop_count == last_loop) begin
            if (stall_cnt < STALL_END) begin
              stall_cnt_nxt      = stall_inc;
              result.force_black = (stall_inc == STALL_END);
            end
          end else begin
            last_loop_nxt = loop_count;
            stall_cnt_nxt = '0;
          end
        end
        if (countdown != '0) begin
          countdown_nxt = countdown - ibt_pkg::CNT_W'(1);
        end else if (!buttons_held) begin
          result.blank_request = 1'b1;
          countdown_nxt        = reload;
          if (!blanked) begin
            pattern_cnt_nxt = '0;
          end
          blanked_nxt   = 1'b1;
          stall_cnt_nxt = '0;
        end
      end
      ibt_pkg::KIND_EVENT: begin
        if (blanked) begin
          result.unblank_request = 1'b1;
          blanked_nxt            = 1'b0;
          stall_cnt_nxt          = '0;
        end
        countdown_nxt = reload;
      end
      default: begin
        countdown_nxt = reload;
      end
    endcase
    result.blanked = blanked_nxt;
  end

  `IBT_ASSERT_IMPL(a_req_excl, item_valid, !(result.blank_request && result.unblank_request), "blank and unblank requested together")
  `IBT_ASSERT_IMPL(a_black_blanked, item_valid && result.force_black, blanked && blanked_nxt, "force_black outside blanked state")

endmodule

@@ rtl/inactivity_blank_timer_core.sv @@
// Inactivity blank timer: idle countdown, blank requests, stall watchdog and pattern pulses.
// The block takes one item per clock cycle while the output is not stalled and returns
// exactly one result per item: the item passes through the input register and then the
// result register, with the state update done by the logic between them. Ticks count
// the idle countdown down and any other event reloads it; a configuration write
// saturates the seconds value to 1..9999, reloads the countdown to ten ticks per second
// and takes effect at once.
`include "assert_macros.svh"

module inactivity_blank_timer_core #(
  parameter int PATTERN_TICKS = 600,
  parameter int STALL_LIMIT   = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [0] buttons_held, [16:1] loop_count, rest zero
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] blank_request, [1] unblank_request,
                                  // [2] force_black, [3] pattern_change, [4] blanked
  input  logic        cfg_we,
  input  logic [13:0] cfg_wdata
);

  localparam int PCW = $clog2(PATTERN_TICKS);
  localparam int SCW = $clog2(STALL_LIMIT + 1);
  localparam logic [PCW-1:0] PATTERN_LAST = PCW'(PATTERN_TICKS - 1);

  logic                        in_valid_r;
  ibt_pkg::kind_t              kind_r;
  logic                        held_r;
  logic [ibt_pkg::LOOP_W-1:0]  loop_r;

  logic [ibt_pkg::CNT_W-1:0]   reload_r;
  logic [ibt_pkg::CNT_W-1:0]   countdown_r;
  logic                        blanked_r;
  logic [SCW-1:0]              stall_cnt_r;
  logic [ibt_pkg::LOOP_W-1:0]  last_loop_r;
  logic [PCW-1:0]              pattern_cnt_r;

  logic                        out_valid_r;
  ibt_pkg::result_t            result_r;

  logic [ibt_pkg::CNT_W-1:0]   countdown_nxt;
  logic                        blanked_nxt;
  logic [SCW-1:0]              stall_cnt_nxt;
  logic [ibt_pkg::LOOP_W-1:0]  last_loop_nxt;
  logic [PCW-1:0]              pattern_cnt_nxt;
  ibt_pkg::result_t            result_nxt;

  logic                        advance;
  logic                        step;
  logic [ibt_pkg::SEC_W-1:0]   seconds_sat;
  logic [ibt_pkg::CNT_W-1:0]   reload_nxt;

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    priority if (cfg_wdata < ibt_pkg::SECONDS_MIN) begin
      seconds_sat = ibt_pkg::SECONDS_MIN;
    end else if (cfg_wdata >= ibt_pkg::SECONDS_CEIL) begin
      seconds_sat = ibt_pkg::SECONDS_MAX;
    end else begin
      seconds_sat = cfg_wdata;
    end
  end

  assign reload_nxt = ibt_pkg::CNT_W'(seconds_sat) * ibt_pkg::TICKS_PER_SEC;

  ibt_step #(
    .PATTERN_TICKS (PATTERN_TICKS),
    .STALL_LIMIT   (STALL_LIMIT)
  ) u_step (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (step),
    .kind            (kind_r),
    .buttons_held    (held_r),
    .loop_count      (loop_r),
    .reload          (reload_r),
    .countdown       (countdown_r),
    .blanked         (blanked_r),
    .stall_cnt       (stall_cnt_r),
    .last_loop       (last_loop_r),
    .pattern_cnt     (pattern_cnt_r),
    .countdown_nxt   (countdown_nxt),
    .blanked_nxt     (blanked_nxt),
    .stall_cnt_nxt   (stall_cnt_nxt),
    .last_loop_nxt   (last_loop_nxt),
    .pattern_cnt_nxt (pattern_cnt_nxt),
    .result          (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (in_tready) begin
      kind_r <= ibt_pkg::kind_t'(in_tuser);
      held_r <= in_tdata[0];
      loop_r <= in_tdata[16:1];
    end
    if (step) begin
      result_r <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      reload_r      <= ibt_pkg::RELOAD_RESET;
      countdown_r   <= ibt_pkg::RELOAD_RESET;
      blanked_r     <= 1'b0;
      stall_cnt_r   <= '0;
      last_loop_r   <= '0;
      pattern_cnt_r <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        reload_r      <= reload_nxt;
        countdown_r   <= reload_nxt;
        pattern_cnt_r <= PATTERN_LAST;
      end else if (step) begin
        countdown_r   <= countdown_nxt;
        pattern_cnt_r <= pattern_cnt_nxt;
      end
      if (step) begin
        blanked_r   <= blanked_nxt;
        stall_cnt_r <= stall_cnt_nxt;
        last_loop_r <= last_loop_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, result_r};

  `IBT_ASSERT(a_stall_range, stall_cnt_r <= SCW'(STALL_LIMIT), "stall count above limit")
  `IBT_ASSERT(a_pattern_range, pattern_cnt_r <= PATTERN_LAST, "pattern count out of range")
  `IBT_ASSERT(a_reload_range, reload_r != '0, "reload value is zero")
  `IBT_ASSERT_IMPL(a_blank_status, out_valid_r && result_r.blank_request, result_r.blanked, "blank request without blanked status")
  `IBT_ASSERT_IMPL(a_unblank_status, out_valid_r && result_r.unblank_request, !result_r.blanked, "unblank request with blanked status")

endmodule
